// ===== hdl/u2u8_pkg.sv =====
`default_nettype none

package u2u8_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;
	localparam int unsigned JOB_DEPTH_DEF   = 4;

	localparam int unsigned UNIT_W      = 16;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned LEN_OUT_W   = 16;

	// most bytes one code unit can yield: flushed high surrogate plus a BMP unit
	localparam int unsigned JOB_BYTES = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COUNT_ONLY = 8'd1;

	localparam logic [UNIT_W-1:0] CAPACITY_RST = 16'd256;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	localparam logic [UNIT_W-1:0] ONE_BYTE_MAX = 16'h007F;
	localparam logic [UNIT_W-1:0] TWO_BYTE_MAX = 16'h07FF;
	localparam logic [10:0]       SUPP_OFFSET  = 11'h040;

	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT  = 8'h80;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [2:0]                n_bytes;
		logic                      has_term;
		logic                      term_valid;
		logic [LEN_OUT_W-1:0]      length;
	} job_t;

endpackage

`default_nettype wire

// ===== hdl/u2u8_unit_if.sv =====
`default_nettype none

interface u2u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;

	modport source (output valid, code_unit, input ready);
	modport sink   (input valid, code_unit, output ready);
endinterface

`default_nettype wire

// ===== hdl/u2u8_byte_if.sv =====
`default_nettype none

interface u2u8_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic [15:0] length;

	modport source (output valid, out_byte, byte_valid, last, length, input ready);
	modport sink   (input valid, out_byte, byte_valid, last, length, output ready);
endinterface

`default_nettype wire

// ===== hdl/u2u8_cfg_if.sv =====
`default_nettype none

interface u2u8_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/u2u8_front.sv =====
`default_nettype none

module u2u8_front import u2u8_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	u2u8_unit_if.sink     units,
	u2u8_cfg_if.sink      cfg,
	output job_t          job,
	output logic          job_valid,
	input  logic          job_ready
);

	localparam int unsigned CW = ((LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W) + 1;

	typedef struct packed {
		logic                   put;
		logic                   stp;
		logic [LENGTH_BITS-1:0] bw;
	} emit_t;

	typedef struct packed {
		logic [2:0][7:0] b;
		logic [2:0]      n;
	} bmp_t;

	function automatic emit_t emit_step(input logic stp, input logic [LENGTH_BITS-1:0] bw,
			input logic [2:0] k, input logic cnt, input logic [15:0] cap);
		emit_t            r;
		logic [LENGTH_BITS:0] s;
		logic [CW-1:0]    need;
		r.put = 1'b0;
		r.stp = stp;
		r.bw  = bw;
		s     = {1'b0, bw} + (LENGTH_BITS+1)'(k);
		need  = CW'(bw) + CW'(k) + CW'(1);
		if (!stp) begin
			if (cnt) begin
				r.bw = s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
			end else if (need > CW'(cap)) begin
				r.stp = 1'b1;
			end else begin
				r.put = 1'b1;
				r.bw  = s[LENGTH_BITS-1:0];
			end
		end
		return r;
	endfunction

	function automatic bmp_t enc_bmp(input logic [15:0] u);
		bmp_t r;
		r.b = '0;
		if (u <= ONE_BYTE_MAX) begin
			r.b[0] = {1'b0, u[6:0]};
			r.n    = 3'd1;
		end else if (u <= TWO_BYTE_MAX) begin
			r.b[0] = LEAD2 | {3'b000, u[10:6]};
			r.b[1] = CONT | {2'b00, u[5:0]};
			r.n    = 3'd2;
		end else begin
			r.b[0] = LEAD3 | {4'h0, u[15:12]};
			r.b[1] = CONT | {2'b00, u[11:6]};
			r.b[2] = CONT | {2'b00, u[5:0]};
			r.n    = 3'd3;
		end
		return r;
	endfunction

	logic [15:0]            capacity_q;
	logic                   count_only_q;
	logic [15:0]            pend_hi_q;
	logic                   pend_valid_q;
	logic [LENGTH_BITS-1:0] bw_q;
	logic                   stopped_q;

	logic [15:0]     u;
	logic            is_hi, is_lo, is_zero, pair, flush, main_do;
	bmp_t            hi_enc, u_enc;
	logic [10:0]     z;
	logic [3:0][7:0] main_b;
	logic [2:0]      main_k;
	emit_t           e1, e2;
	logic [CW-1:0]   len_ext;
	logic            accept;

	assign u       = units.code_unit;
	assign is_hi   = (u[15:10] == HI_SURR_TAG);
	assign is_lo   = (u[15:10] == LO_SURR_TAG);
	assign is_zero = (u == '0);
	assign pair    = pend_valid_q && is_lo;
	assign flush   = pend_valid_q && !is_lo;
	assign main_do = pair || (!is_zero && !is_hi);

	assign hi_enc = enc_bmp(pend_hi_q);
	assign u_enc  = enc_bmp(u);
	assign z      = {1'b0, pend_hi_q[9:0]} + SUPP_OFFSET;

	always_comb begin
		if (pair) begin
			main_b[0] = LEAD4 | {5'b00000, z[10:8]};
			main_b[1] = CONT | {2'b00, z[7:2]};
			main_b[2] = CONT | {2'b00, z[1:0], u[9:6]};
			main_b[3] = CONT | {2'b00, u[5:0]};
			main_k    = 3'd4;
		end else begin
			main_b = {8'h00, u_enc.b};
			main_k = u_enc.n;
		end
	end

	// flush of a held high surrogate goes first; its outcome feeds the unit's own check
	always_comb begin
		e1 = emit_step(stopped_q, bw_q, 3'd3, count_only_q, capacity_q);
		if (!flush) begin
			e1 = '{put: 1'b0, stp: stopped_q, bw: bw_q};
		end
		e2 = emit_step(e1.stp, e1.bw, main_k, count_only_q, capacity_q);
		if (!main_do) begin
			e2 = '{put: 1'b0, stp: e1.stp, bw: e1.bw};
		end
	end

	assign len_ext = CW'(e1.bw);

	always_comb begin
		job = '0;
		if (e1.put) begin
			job.bytes[2:0] = hi_enc.b;
			job.bytes[5:3] = main_b[2:0];
			job.n_bytes    = 3'd3 + (e2.put ? main_k : 3'd0);
		end else begin
			job.bytes[3:0] = main_b;
			job.n_bytes    = e2.put ? main_k : 3'd0;
		end
		job.has_term   = is_zero;
		job.term_valid = !count_only_q;
		job.length     = (len_ext > CW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
	end

	assign units.ready = job_ready;
	assign job_valid   = units.valid && ((job.n_bytes != 3'd0) || job.has_term);
	assign accept      = units.valid && job_ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RST;
			count_only_q <= 1'b0;
			pend_hi_q    <= '0;
			pend_valid_q <= 1'b0;
			bw_q         <= '0;
			stopped_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_CAPACITY) begin
					capacity_q <= cfg.data;
				end else if (cfg.index == REG_COUNT_ONLY) begin
					count_only_q <= cfg.data[0];
				end
			end
			if (accept) begin
				pend_valid_q <= !pair && is_hi && !e1.stp;
				pend_hi_q    <= u;
				if (is_zero) begin
					bw_q      <= '0;
					stopped_q <= 1'b0;
				end else begin
					bw_q      <= e2.bw;
					stopped_q <= e2.stp;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/u2u8_job_fifo.sv =====
`default_nettype none

module u2u8_job_fifo import u2u8_pkg::*; #(
	parameter int unsigned DEPTH = JOB_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_valid,
	output logic wr_ready,
	output job_t rd_job,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/u2u8_back.sv =====
`default_nettype none

module u2u8_back import u2u8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_valid,
	output logic        job_ready,
	u2u8_byte_if.source result
);

	job_t       cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q, last_q;
	logic [15:0] length_q;

	logic [2:0] total;
	logic       load, last_res, take_last, is_byte;

	assign total     = cur_q.n_bytes + {2'b00, cur_q.has_term};
	assign last_res  = ((idx_q + 3'd1) == total);
	assign load      = busy_q && (!out_valid_q || result.ready);
	assign take_last = load && last_res;
	assign is_byte   = (idx_q < cur_q.n_bytes);

	// next job is taken in the same cycle the current one hands over its final result
	assign job_ready = !busy_q || take_last;

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.byte_valid = byte_valid_q;
	assign result.last       = last_q;
	assign result.length     = length_q;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			cur_q <= job;
		end
		if (load) begin
			if (is_byte) begin
				out_byte_q   <= cur_q.bytes[idx_q];
				byte_valid_q <= 1'b1;
				last_q       <= 1'b0;
				length_q     <= '0;
			end else begin
				out_byte_q   <= '0;
				byte_valid_q <= cur_q.term_valid;
				last_q       <= 1'b1;
				length_q     <= cur_q.length;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_valid && job_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (take_last) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/utf16_to_utf8_encoder.sv =====
// channel  dir  payload                                  request when
// units    in   code_unit[15:0]                          valid && ready
// result   out  out_byte[7:0] byte_valid last length     valid && ready
// cfg      in   index[7:0] data[15:0]                    valid && ready (ready tied high)
//
// The front takes one code unit per cycle while the job queue has room.
// The back sends one result per cycle unless the result channel stalls; a unit
// yields 0 to 6 results (mostly 1 to 4), and the byte serialiser sets the rate.
// Reset: capacity 256, count_only 0, string state clear; no clearing pass.
// An output stall fills the job queue (JOB_DEPTH entries), then units.ready drops.
`default_nettype none

module utf16_to_utf8_encoder import u2u8_pkg::*; #(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int unsigned JOB_DEPTH   = JOB_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	u2u8_unit_if.sink   units,
	u2u8_byte_if.source result,
	u2u8_cfg_if.sink    cfg
);

	job_t fr_job, bk_job;
	logic fr_valid, fr_ready, bk_valid, bk_ready;

	u2u8_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.units     (units),
		.cfg       (cfg),
		.job       (fr_job),
		.job_valid (fr_valid),
		.job_ready (fr_ready)
	);

	u2u8_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_job   (fr_job),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_job   (bk_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready)
	);

	u2u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (bk_job),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.result    (result)
	);

endmodule

`default_nettype wire
